// ----- rtl/core/frame_allocator_page_mapper_assert.svh -----
// assertion macros for the frame allocator page mapper
`ifndef FRAME_ALLOCATOR_PAGE_MAPPER_ASSERT_SVH
`define FRAME_ALLOCATOR_PAGE_MAPPER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FAPM_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define FAPM_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition");
`else
`define FAPM_ASSERT_IMPL(label, clk, rst_n, prop)
`define FAPM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/fapm_pkg.sv -----
// ----------------------------------------------------------------------------
// fapm_pkg
// types and constants of the frame allocator page mapper
// ----------------------------------------------------------------------------
package fapm_pkg;
	localparam int NUM_FRAMES_DEF = 64;
	localparam int FREE_DEPTH_DEF = 64;
	localparam int TBL_ENTRIES    = 512;
	localparam int IDX_W          = 9;
	localparam int FRAME_W        = 6;
	localparam int ENT_W          = 9;
	localparam int CNT7_W         = 7;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_MAP   = 2'd2;
	localparam logic [1:0] OP_AMAP  = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOM  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic CFG_FRAME_LIMIT = 1'b0;
	localparam logic CFG_FIRST_FRESH = 1'b1;

	// memory port request from sequencer to table memory
	typedef struct packed {
		logic             rd;
		logic             wr;
		logic             root;
		logic [11:0]      frame;
		logic [IDX_W-1:0] idx;
		logic [ENT_W-1:0] wdata;
	} mem_req_t;
endpackage

// ----- rtl/core/fapm_table_mem.sv -----
// ----------------------------------------------------------------------------
// fapm_table_mem
// root table and the frame store, one access a cycle
// ----------------------------------------------------------------------------
module fapm_table_mem #(
	parameter int NUM_FRAMES = fapm_pkg::NUM_FRAMES_DEF,
	localparam int FB = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fapm_pkg::mem_req_t           req,
	output logic [fapm_pkg::ENT_W-1:0]   rdata
);
	localparam int IW = fapm_pkg::IDX_W;
	logic [fapm_pkg::ENT_W-1:0] root_mem [fapm_pkg::TBL_ENTRIES];
	logic [fapm_pkg::ENT_W-1:0] store_mem [NUM_FRAMES*fapm_pkg::TBL_ENTRIES];
	logic [fapm_pkg::ENT_W-1:0] root_rd_q, store_rd_q;
	logic sel_root_q;
	logic [FB+IW-1:0] addr;

	assign addr = {req.frame[FB-1:0], req.idx};

	always_ff @(posedge clk) begin
		if (req.wr && req.root) root_mem[req.idx] <= req.wdata;
		if (req.wr && !req.root) store_mem[addr] <= req.wdata;
		root_rd_q  <= root_mem[req.idx];
		store_rd_q <= store_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_root_q <= 1'b0;
		end else begin
			if (req.rd) sel_root_q <= req.root;
		end
	end

	assign rdata = sel_root_q ? root_rd_q : store_rd_q;
endmodule

// ----- rtl/core/fapm_free_stack.sv -----
// ----------------------------------------------------------------------------
// fapm_free_stack
// free frame stack memory with registered read
// ----------------------------------------------------------------------------
module fapm_free_stack #(
	parameter int FREE_DEPTH = fapm_pkg::FREE_DEPTH_DEF,
	localparam int AB = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           wr,
	input  logic [AB-1:0]                  waddr,
	input  logic [fapm_pkg::FRAME_W-1:0]   wdata,
	input  logic [AB-1:0]                  raddr,
	output logic [fapm_pkg::FRAME_W-1:0]   rdata
);
	logic [fapm_pkg::FRAME_W-1:0] mem [FREE_DEPTH];
	always_ff @(posedge clk) begin
		if (wr) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/frame_allocator_page_mapper.sv -----
// ----------------------------------------------------------------------------
// frame_allocator_page_mapper
// physical frame allocator with a four-level page-table mapper
// ----------------------------------------------------------------------------
// usage:
//  - command channel: opcode, virtual_address, frame_number, writable, user are
//    taken at a clock edge with start high and busy low; busy stays high until
//    the result is out
//  - result channel: result_frame and status are valid for one cycle with
//    done high; the receiver cannot stall, so the result beat is never held
//  - config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//    ready; index 0 frame_limit, 1 first_fresh_frame (also reloads the
//    fresh counter)
//  - sequence: free goes from the free state, which pushes the frame, to the
//    done state; an allocation adds a decide state plus clearing the new frame
//    one entry a cycle through the single table memory port
//  - each walk level issues a read and takes the data back when the table
//    exists; a missing table adds its allocation and one link write, so an
//    allocate-and-map can take up to four new frames
//  - the free stack pop adds a state in which the stack memory read returns
//  - reset starts a pass that zeroes all 512 root table entries with busy high;
//    the frame store and stack hold garbage until written
// ----------------------------------------------------------------------------
`include "frame_allocator_page_mapper_assert.svh"
module frame_allocator_page_mapper #(
	parameter int NUM_FRAMES = fapm_pkg::NUM_FRAMES_DEF,
	parameter int FREE_DEPTH = fapm_pkg::FREE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [47:0] virtual_address,
	input  logic [5:0]  frame_number,
	input  logic        writable,
	input  logic        user,
	output logic        done,
	output logic [5:0]  result_frame,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	localparam int SB = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
	localparam int CW = $clog2(FREE_DEPTH + 1);
	localparam int FW = fapm_pkg::FRAME_W;
	localparam int EW = fapm_pkg::ENT_W;
	localparam int IW = fapm_pkg::IDX_W;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ALLOC = 4'd1;  // decide source of a frame
	localparam logic [3:0] S_POP   = 4'd2;  // stack read returns
	localparam logic [3:0] S_CLEAR = 4'd3;  // zero 512 entries
	localparam logic [3:0] S_RD    = 4'd4;  // issue table read
	localparam logic [3:0] S_RW    = 4'd5;  // read data back
	localparam logic [3:0] S_LEAF  = 4'd6;
	localparam logic [3:0] S_FREE  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;
	localparam logic [3:0] S_LINK  = 4'd9;  // write new table entry
	localparam logic [3:0] S_INIT  = 4'd10; // zero the root table after reset

	logic [3:0] state_q;
	logic [6:0] limit_q, fresh_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] op_q;
	logic [47:0] va_q;
	logic [FW-1:0] data_q, new_q, tbl_q, res_q, push_q;
	logic wr_q, usr_q;
	logic [1:0] lvl_q, st_q;
	logic root_q, alloc_data_q;
	logic [IW:0] clr_q;
	logic [EW-1:0] rdata;
	logic [FW-1:0] stk_rd;
	fapm_pkg::mem_req_t req;
	logic stk_wr;

	logic [IW-1:0] idx;
	always_comb begin
		unique case (lvl_q)
			2'd3: idx = va_q[47:39];
			2'd2: idx = va_q[38:30];
			2'd1: idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	fapm_table_mem #(.NUM_FRAMES(NUM_FRAMES)) u_mem (
		.clk(clk), .arst_n(arst_n), .req(req), .rdata(rdata));

	fapm_free_stack #(.FREE_DEPTH(FREE_DEPTH)) u_stk (
		.clk(clk), .wr(stk_wr), .waddr(cnt_q[SB-1:0]), .wdata(push_q),
		.raddr(SB'(cnt_q - CW'(1))), .rdata(stk_rd));

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		req = '0;
		req.idx = idx;
		req.root = root_q;
		req.frame = 12'(tbl_q);
		unique case (state_q)
			S_INIT: begin
				req.wr = 1'b1;
				req.root = 1'b1;
				req.idx = clr_q[IW-1:0];
			end
			S_CLEAR: begin
				req.wr = 1'b1;
				req.root = 1'b0;
				req.frame = 12'(new_q);
				req.idx = clr_q[IW-1:0];
			end
			S_RD: req.rd = 1'b1;
			S_LINK: begin
				req.wr = 1'b1;
				req.wdata = {usr_q, 2'b11, new_q};
			end
			S_LEAF: begin
				req.wr = 1'b1;
				req.wdata = {usr_q, wr_q, 1'b1, data_q};
			end
			default: ;
		endcase
	end

	// push: free request or give back on failed allocate-and-map
	assign stk_wr = (state_q == S_FREE) && (32'(cnt_q) < FREE_DEPTH);

	logic fresh_ok;
	assign fresh_ok = (fresh_q < limit_q) && (32'(fresh_q) < NUM_FRAMES);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= opcode;
			va_q <= virtual_address;
			wr_q <= writable;
			usr_q <= user;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			limit_q <= 7'd64;
			fresh_q <= 7'd0;
			cnt_q <= '0;
			lvl_q <= 2'd3;
			root_q <= 1'b1;
			alloc_data_q <= 1'b0;
			clr_q <= '0;
			st_q <= fapm_pkg::ST_OK;
			res_q <= '0;
			data_q <= '0;
			new_q <= '0;
			tbl_q <= '0;
			push_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fapm_pkg::CFG_FRAME_LIMIT) limit_q <= cfg_data;
				else fresh_q <= cfg_data;
			end
			unique case (state_q)
				S_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (IW+1)'(fapm_pkg::TBL_ENTRIES - 1)) begin
						clr_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: if (start) begin
					st_q <= fapm_pkg::ST_OK;
					res_q <= '0;
					lvl_q <= 2'd3;
					root_q <= 1'b1;
					data_q <= frame_number;
					push_q <= frame_number;
					// the first frame taken is the data frame
					alloc_data_q <= (opcode == fapm_pkg::OP_ALLOC) ||
						(opcode == fapm_pkg::OP_AMAP);
					unique case (opcode)
						fapm_pkg::OP_FREE: state_q <= S_FREE;
						fapm_pkg::OP_MAP: state_q <= S_RD;
						default: state_q <= S_ALLOC;
					endcase
				end
				S_ALLOC: begin
					if (cnt_q != '0) begin
						state_q <= S_POP;
					end else if (fresh_ok) begin
						new_q <= fresh_q[FW-1:0];
						fresh_q <= fresh_q + 7'd1;
						clr_q <= '0;
						state_q <= S_CLEAR;
					end else begin
						st_q <= fapm_pkg::ST_OOM;
						if (!alloc_data_q && op_q == fapm_pkg::OP_AMAP) begin
							state_q <= S_FREE; // give data frame back
						end else state_q <= S_DONE;
					end
				end
				S_POP: begin
					cnt_q <= cnt_q - CW'(1);
					new_q <= stk_rd;
					clr_q <= '0;
					state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (IW+1)'(fapm_pkg::TBL_ENTRIES - 1)) begin
						if (alloc_data_q) begin
							alloc_data_q <= 1'b0;
							data_q <= new_q;
							push_q <= new_q;
							res_q <= new_q;
							state_q <= (op_q == fapm_pkg::OP_AMAP) ? S_RD : S_DONE;
						end else state_q <= S_LINK;
					end
				end
				S_RD: state_q <= (lvl_q == 2'd0) ? S_LEAF : S_RW;
				S_RW: begin
					if (rdata[6]) begin
						tbl_q <= rdata[FW-1:0];
						root_q <= 1'b0;
						lvl_q <= lvl_q - 2'd1;
						state_q <= S_RD;
					end else state_q <= S_ALLOC;
				end
				S_LINK: begin
					tbl_q <= new_q;
					root_q <= 1'b0;
					lvl_q <= lvl_q - 2'd1;
					state_q <= S_RD;
				end
				S_LEAF: state_q <= S_DONE;
				S_FREE: begin
					if (32'(cnt_q) < FREE_DEPTH) cnt_q <= cnt_q + CW'(1);
					else if (op_q == fapm_pkg::OP_FREE) st_q <= fapm_pkg::ST_FULL;
					if (op_q == fapm_pkg::OP_AMAP) res_q <= '0;
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = (state_q == S_DONE);
	assign result_frame = res_q;
	assign status = st_q;

	`FAPM_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 32'(cnt_q) <= FREE_DEPTH)
	`FAPM_ASSERT_IMPL(a_done_one, clk, arst_n, done |=> !done)
	`FAPM_ASSERT_NEVER(a_oom_res, clk, arst_n,
		done && status != fapm_pkg::ST_OK && result_frame != '0)
endmodule

// ----- tb/sv/frame_allocator_page_mapper_checker.sv -----
// ----------------------------------------------------------------------------
// frame_allocator_page_mapper_checker
// watches the command, config and result channels, keeps a shadow of the
// allocator and page tables, and compares every result beat in order
// ----------------------------------------------------------------------------
module frame_allocator_page_mapper_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic [47:0] virtual_address,
	input  logic [5:0]  frame_number,
	input  logic        writable,
	input  logic        user,
	input  logic        done,
	input  logic [5:0]  result_frame,
	input  logic [1:0]  status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic [5:0] frame;
		logic [1:0] st;
	} outcome_t;

	// expected beats in order, written at the command beat, read at done
	outcome_t   expect_ring [0:15];
	int         issued, retired;
	logic [6:0] limit_reg, first_reg, fresh_ctr, stack_cnt;
	logic [8:0] root_tbl [0:511];
	logic [8:0] page_mem [0:64*512-1];
	logic [5:0] stack_mem [0:63];

	assign pending = issued - retired;

	// pop the free stack or take a fresh frame, clearing the frame it gives
	function automatic bit grab_frame(output logic [5:0] f);
		if (stack_cnt > 7'd0) begin
			stack_cnt = stack_cnt - 7'd1;
			f = stack_mem[stack_cnt[5:0]];
		end else begin
			if (fresh_ctr >= limit_reg || fresh_ctr >= 7'd64)
				return 0;
			f = fresh_ctr[5:0];
			fresh_ctr = fresh_ctr + 7'd1;
		end
		for (int i = 0; i < 512; i++)
			page_mem[f*512+i] = '0;
		return 1;
	endfunction

	function automatic bit give_frame(input logic [5:0] f);
		if (stack_cnt >= 7'd64)
			return 0;
		stack_mem[stack_cnt[5:0]] = f;
		stack_cnt = stack_cnt + 7'd1;
		return 1;
	endfunction

	// three-level walk, creating missing tables, then the leaf write
	function automatic bit walk_and_map(input logic [47:0] va, input logic [5:0] leaf,
			input logic wr, input logic usr);
		bit         at_root;
		logic [5:0] cur, nf;
		logic [8:0] idx, ent;
		at_root = 1;
		cur = '0;
		for (int lvl = 3; lvl >= 1; lvl--) begin
			idx = va[12+9*lvl +: 9];
			ent = at_root ? root_tbl[idx] : page_mem[cur*512+idx];
			if (!ent[6]) begin
				if (!grab_frame(nf))
					return 0;
				ent = {usr, 1'b1, 1'b1, nf};
				if (at_root)
					root_tbl[idx] = ent;
				else
					page_mem[cur*512+idx] = ent;
			end
			at_root = 0;
			cur = ent[5:0];
		end
		page_mem[cur*512+va[20:12]] = {usr, wr, 1'b1, leaf};
		return 1;
	endfunction

	function automatic outcome_t predict_command(input logic [1:0] op,
			input logic [47:0] va, input logic [5:0] fn, input logic wr, input logic usr);
		outcome_t   o;
		logic [5:0] f;
		o = '{frame: '0, st: fapm_pkg::ST_OK};
		case (op)
			fapm_pkg::OP_ALLOC: begin
				if (grab_frame(f))
					o.frame = f;
				else
					o.st = fapm_pkg::ST_OOM;
			end
			fapm_pkg::OP_FREE: begin
				if (!give_frame(fn))
					o.st = fapm_pkg::ST_FULL;
			end
			fapm_pkg::OP_MAP: begin
				if (!walk_and_map(va, fn, wr, usr))
					o.st = fapm_pkg::ST_OOM;
			end
			default: begin
				if (!grab_frame(f)) begin
					o.st = fapm_pkg::ST_OOM;
				end else if (!walk_and_map(va, f, wr, usr)) begin
					void'(give_frame(f));
					o.st = fapm_pkg::ST_OOM;
				end else begin
					o.frame = f;
				end
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			limit_reg = 7'd64;
			first_reg = 7'd0;
			fresh_ctr = 7'd0;
			stack_cnt = 7'd0;
			for (int i = 0; i < 512; i++)
				root_tbl[i] = '0;
			issued = 0;
			retired = 0;
			errors = 0;
		end else begin
			if (done) begin
				if (issued == retired) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat: frame %0d status %0d",
							result_frame, status);
				end else begin
					want = expect_ring[retired % 16];
					retired++;
					if (want.frame !== result_frame || want.st !== status) begin
						errors++;
						if (errors <= 10)
							$display({"result mismatch: frame exp %0d got %0d,",
								" status exp %0d got %0d"},
								want.frame, result_frame, want.st, status);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fapm_pkg::CFG_FRAME_LIMIT) begin
					limit_reg = cfg_data;
				end else begin
					first_reg = cfg_data;
					fresh_ctr = cfg_data;
				end
			end
			if (start && !busy) begin
				expect_ring[issued % 16] = predict_command(opcode, virtual_address,
					frame_number, writable, user);
				issued++;
			end
		end
	end
endmodule

// ----- tb/sv/frame_allocator_page_mapper_test.sv -----
// ----------------------------------------------------------------------------
// frame_allocator_page_mapper_test
// drives directed and random allocate, free and map commands in bursts under
// several frame limit and fresh counter settings; the checker predicts and
// compares every result beat
// ----------------------------------------------------------------------------
module frame_allocator_page_mapper_test;
	logic        clk, arst_n;
	logic        start, busy, done;
	logic [1:0]  opcode, status;
	logic [47:0] virtual_address;
	logic [5:0]  frame_number, result_frame;
	logic        writable, user;
	logic        cfg_valid, cfg_ready, cfg_index;
	logic [6:0]  cfg_data;
	int          errors, pending;
	longint      cycle_cnt;
	logic [26:0] region_hi [0:3];

	frame_allocator_page_mapper uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .virtual_address(virtual_address),
		.frame_number(frame_number), .writable(writable), .user(user),
		.done(done), .result_frame(result_frame), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	frame_allocator_page_mapper_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .virtual_address(virtual_address),
		.frame_number(frame_number), .writable(writable), .user(user),
		.done(done), .result_frame(result_frame), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: reports a failure and ends the run if the cycle count passes its limit
	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt > 4000000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// one command beat; start stays high until the block takes it
	task automatic issue(input logic [1:0] op, input logic [47:0] va,
			input logic [5:0] fn, input logic wr, input logic usr);
		@(negedge clk);
		opcode = op;
		virtual_address = va;
		frame_number = fn;
		writable = wr;
		user = usr;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_for(input int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// wait until every result beat is back, then let the block settle
	task automatic drain();
		idle_for(0);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// addresses mostly share upper bits so walks reuse existing tables
	function automatic logic [47:0] pick_address();
		if ($urandom_range(0, 3) == 0)
			return 48'({$urandom, $urandom});
		return {region_hi[$urandom_range(0, 3)], 21'($urandom)};
	endfunction

	task automatic random_phase(input int count, input int free_bias);
		int         left, burst, roll;
		logic [1:0] op;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && left > 0) begin
				roll = $urandom_range(0, 99);
				if (roll < free_bias)
					op = fapm_pkg::OP_FREE;
				else
					op = 2'($urandom_range(0, 3));
				issue(op, pick_address(), 6'($urandom), 1'($urandom), 1'($urandom));
				burst--;
				left--;
			end
			// some bursts run straight into the next one
			if ($urandom_range(0, 2) != 0)
				idle_for($urandom_range(0, 12));
		end
	endtask

	initial begin
		start = 1'b0;
		opcode = fapm_pkg::OP_ALLOC;
		virtual_address = '0;
		frame_number = '0;
		writable = 1'b0;
		user = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = fapm_pkg::CFG_FRAME_LIMIT;
		cfg_data = '0;
		arst_n = 1'b0;
		region_hi[0] = '0;
		region_hi[1] = '1;
		region_hi[2] = 27'($urandom);
		region_hi[3] = 27'($urandom);
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes and every opcode at reset settings
		issue(fapm_pkg::OP_ALLOC, '0, '0, 1'b0, 1'b0);
		issue(fapm_pkg::OP_MAP, '0, 6'd63, 1'b1, 1'b1);
		issue(fapm_pkg::OP_MAP, 48'hFFFF_FFFF_FFFF, 6'd0, 1'b0, 1'b0);
		issue(fapm_pkg::OP_AMAP, 48'h0000_0020_1000, 6'd5, 1'b1, 1'b0);
		issue(fapm_pkg::OP_AMAP, 48'hFFFF_FFFF_F000, 6'd0, 1'b0, 1'b1);
		issue(fapm_pkg::OP_FREE, '0, 6'd63, 1'b0, 1'b0);
		issue(fapm_pkg::OP_FREE, '0, 6'd0, 1'b0, 1'b0);
		issue(fapm_pkg::OP_ALLOC, '0, '0, 1'b0, 1'b0);
		issue(fapm_pkg::OP_FREE, '0, 6'd42, 1'b1, 1'b1);
		drain();

		// fresh counter shut off: out of memory, and a failed allocate-and-map
		// that pushes its data frame back
		write_reg(fapm_pkg::CFG_FRAME_LIMIT, 7'd0);
		issue(fapm_pkg::OP_AMAP, 48'h5555_5555_5000, 6'd0, 1'b1, 1'b1);
		issue(fapm_pkg::OP_MAP, 48'hAAAA_AAAA_A000, 6'd9, 1'b0, 1'b0);
		issue(fapm_pkg::OP_ALLOC, '0, '0, 1'b0, 1'b0);
		issue(fapm_pkg::OP_ALLOC, '0, '0, 1'b0, 1'b0);
		issue(fapm_pkg::OP_AMAP, 48'h1234_5678_9000, 6'd0, 1'b0, 1'b0);
		issue(fapm_pkg::OP_ALLOC, '0, '0, 1'b0, 1'b0);
		drain();

		// counter at the top of storage
		write_reg(fapm_pkg::CFG_FRAME_LIMIT, 7'd64);
		write_reg(fapm_pkg::CFG_FIRST_FRESH, 7'd64);
		issue(fapm_pkg::OP_ALLOC, '0, '0, 1'b0, 1'b0);
		issue(fapm_pkg::OP_MAP, 48'h0F0F_0F0F_0000, 6'd1, 1'b1, 1'b0);
		drain();

		// flood of frees to fill the stack and overflow it
		for (int i = 0; i < 68; i++)
			issue(fapm_pkg::OP_FREE, '0, 6'($urandom), 1'b0, 1'b0);
		drain();

		write_reg(fapm_pkg::CFG_FIRST_FRESH, 7'd0);
		random_phase(60, 10);
		drain();

		write_reg(fapm_pkg::CFG_FRAME_LIMIT, 7'd20);
		write_reg(fapm_pkg::CFG_FIRST_FRESH, 7'd5);
		random_phase(50, 25);
		drain();

		write_reg(fapm_pkg::CFG_FRAME_LIMIT, 7'd1);
		write_reg(fapm_pkg::CFG_FIRST_FRESH, 7'd0);
		random_phase(30, 30);
		drain();

		write_reg(fapm_pkg::CFG_FRAME_LIMIT, 7'd64);
		write_reg(fapm_pkg::CFG_FIRST_FRESH, 7'd60);
		random_phase(60, 20);
		drain();

		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
